// File: hw/rtl/cpa_pkg.sv
// ----------------------------------------------------------------------------
// cpa_pkg
// Shared types and codes for the contiguous port allocator: beat layouts,
// opcodes, status codes and the controller/datapath command bundle.
// ----------------------------------------------------------------------------
package cpa_pkg;

    // Request opcodes
    localparam logic [1:0] OP_REGISTER = 2'd0;
    localparam logic [1:0] OP_RELEASE  = 2'd1;
    localparam logic [1:0] OP_APPLY    = 2'd2;
    localparam logic [1:0] OP_QUERY    = 2'd3;

    // Result status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // Request beat
    typedef struct packed {
        logic [1:0] opcode;
        logic [2:0] slot_id;
    } t_in_item;

    // Result beat
    typedef struct packed {
        logic       status;
        logic [2:0] assigned_id;
        logic [3:0] port;
        logic [3:0] active_count;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic latch;       // capture the accepted request
        logic apply_start; // rewind the release walk
        logic apply_step;  // run one queued release
        logic exec;        // finish the request and load the result
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic apply_more;  // queued releases remain in the walk
    } t_dp_status;

endpackage

// File: hw/rtl/cpa_datapath.sv
// ----------------------------------------------------------------------------
// cpa_datapath
// Port table, live and pending counters, release queue and result register.
// Steps are driven one at a time by the controller.
// ----------------------------------------------------------------------------
module cpa_datapath import cpa_pkg::*; #(
    parameter int MAX_IDS     = 8,
    parameter int QUEUE_DEPTH = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    input  t_in_item   i_in_data,
    output t_out_item  o_out_data
);

    localparam int IDX_W = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
    localparam int PW    = $clog2(MAX_IDS + 1);
    localparam int QIW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW   = $clog2(QUEUE_DEPTH + 1);
    localparam int AW    = (PW > QCW) ? PW : QCW;

    // identifier to table index
    function automatic logic [IDX_W-1:0] id_idx(input logic [2:0] id);
        logic [31:0] wide;
        wide = {29'd0, id};
        return wide[IDX_W-1:0];
    endfunction

    // identifier within the table
    function automatic logic id_ok(input logic [2:0] id);
        return ({29'd0, id} < 32'(MAX_IDS));
    endfunction

    logic [PW-1:0]  r_port [MAX_IDS];
    logic [PW-1:0]  n_port [MAX_IDS];
    logic [PW-1:0]  r_live, n_live;
    logic [QCW-1:0] r_pend, n_pend;
    logic [QCW-1:0] r_k, n_k;
    logic [2:0]     r_queue [QUEUE_DEPTH];
    logic [1:0]     r_op;
    logic [2:0]     r_id;
    t_out_item      r_out, n_out;

    logic             q_we;
    logic [2:0]       rel_id;
    logic [PW-1:0]    rel_old;
    logic             rel_hit;
    logic [IDX_W-1:0] rel_idx;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic [PW-1:0]    qry_port;
    logic [PW-1:0]    new_port;
    logic [AW-1:0]    live_w, pend_w, act_w;
    logic [31:0]      act32, port32, aid32;

    // read the queue head of the release walk
    assign rel_id  = r_queue[r_k[QIW-1:0]];
    assign rel_idx = id_idx(rel_id);
    assign rel_old = id_ok(rel_id) ? r_port[rel_idx] : '0;
    assign rel_hit = id_ok(rel_id) && (rel_old != '0);

    // lowest free identifier
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = MAX_IDS - 1; i >= 0; i--) begin
            if (r_port[i] == '0) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign qry_port = id_ok(r_id) ? r_port[id_idx(r_id)] : '0;
    assign new_port = r_live + PW'(1);
    assign o_status.apply_more = (r_k < r_pend);

    // next state of table, counters and result
    always_comb begin
        n_port = r_port;
        n_live = r_live;
        n_pend = r_pend;
        n_k    = r_k;
        n_out  = r_out;
        q_we   = 1'b0;
        port32 = '0;
        aid32  = '0;

        if (i_cmd.apply_start) begin
            n_k = '0;
        end

        // release one queued identifier, close the gap above it
        if (i_cmd.apply_step) begin
            n_k = r_k + QCW'(1);
            if (rel_hit) begin
                for (int i = 0; i < MAX_IDS; i++) begin
                    if (IDX_W'(i) == rel_idx) begin
                        n_port[i] = '0;
                    end else if (r_port[i] > rel_old) begin
                        n_port[i] = r_port[i] - PW'(1);
                    end
                end
                if (r_live != '0) begin
                    n_live = r_live - PW'(1);
                end
            end
        end

        if (i_cmd.exec) begin
            n_out.status      = STATUS_OK;
            n_out.assigned_id = '0;
            n_out.port        = '0;
            case (r_op)
                OP_REGISTER: begin
                    if (free_found) begin
                        n_live           = new_port;
                        n_port[free_idx] = new_port;
                        aid32            = 32'(free_idx);
                        port32           = 32'(new_port);
                        n_out.assigned_id = aid32[2:0];
                        n_out.port        = port32[3:0];
                    end else begin
                        n_out.status = STATUS_FULL;
                    end
                end
                OP_RELEASE: begin
                    if (r_pend >= QCW'(QUEUE_DEPTH)) begin
                        n_out.status = STATUS_FULL;
                    end else begin
                        q_we   = 1'b1;
                        n_pend = r_pend + QCW'(1);
                    end
                end
                OP_APPLY: begin
                    n_pend = '0;
                end
                OP_QUERY: begin
                    port32     = 32'(qry_port);
                    n_out.port = port32[3:0];
                end
                default: begin
                    n_out.status = STATUS_OK;
                end
            endcase
        end

        // active count after the step, held at zero
        live_w = AW'(n_live);
        pend_w = AW'(n_pend);
        act_w  = (live_w > pend_w) ? (live_w - pend_w) : '0;
        act32  = 32'(act_w);
        if (i_cmd.exec) begin
            n_out.active_count = act32[3:0];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_IDS; i++) begin
                r_port[i] <= '0;
            end
            r_live <= '0;
            r_pend <= '0;
            r_k    <= '0;
        end else begin
            r_port <= n_port;
            r_live <= n_live;
            r_pend <= n_pend;
            r_k    <= n_k;
        end
    end

    // payload: request latch, queue and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op <= i_in_data.opcode;
            r_id <= i_in_data.slot_id;
        end
        if (q_we) begin
            r_queue[r_pend[QIW-1:0]] <= r_id;
        end
        r_out <= n_out;
    end

    assign o_out_data = r_out;

endmodule

// File: hw/rtl/cpa_ctrl.sv
// ----------------------------------------------------------------------------
// cpa_ctrl
// Sequencer for the allocator: takes one request, walks the release queue
// on apply, then hands the result to the output register.
// ----------------------------------------------------------------------------
module cpa_ctrl import cpa_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_opcode,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_APPLY,
        S_EXEC
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // issue datapath commands
    always_comb begin
        o_cmd.latch       = accept;
        o_cmd.apply_start = accept && (i_opcode == OP_APPLY);
        o_cmd.apply_step  = (r_state == S_APPLY) && i_status.apply_more;
        o_cmd.exec        = (r_state == S_EXEC) && out_free;
    end

    // advance the sequence
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_opcode == OP_APPLY) ? S_APPLY : S_EXEC;
                end
            end
            S_APPLY: begin
                if (!i_status.apply_more) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (o_cmd.exec) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // hold state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: hw/rtl/contiguous_port_allocator.sv
// ----------------------------------------------------------------------------
// contiguous_port_allocator
// Hands out device identifiers and keeps their port numbers contiguous;
// releases are queued and applied in order on request.
//
//   channel  direction  handshake                     beat
//   request  in         i_in_valid / o_in_ready       t_in_item
//   result   out        o_out_valid / i_out_ready     t_out_item
//
// Register, queue release and query pass the request latch, then load the result
// register once it is free. Apply walks N queued releases one release per cycle
// through the shared port-table update, then loads the result once the walk ends.
// One request is in flight at a time; the next is taken while the result
// still waits in the output register, and a stalled result holds the
// sequencer only at the point of loading the next one.
// Reset is synchronous and clears the port table and counters at once.
// ----------------------------------------------------------------------------
module contiguous_port_allocator import cpa_pkg::*; #(
    parameter int MAX_IDS     = 8,
    parameter int QUEUE_DEPTH = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // sequencer
    cpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_opcode    (i_in_data.opcode),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (dp_cmd),
        .i_status    (dp_status)
    );

    // table, queue and result register
    cpa_datapath #(
        .MAX_IDS     (MAX_IDS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .o_status   (dp_status),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

endmodule

// File: hw/rtl/cpa_checker.sv
// ----------------------------------------------------------------------------
// cpa_checker
// Port-level checks for the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module cpa_checker import cpa_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // one request at a time: ready drops after a beat is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken while another is in flight");

    // a failed request reports no identifier and no port
    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == STATUS_FULL)
        |-> (o_out_data.assigned_id == 3'd0) && (o_out_data.port == 4'd0))
        else $error("full status with identifier or port set");

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind contiguous_port_allocator cpa_checker u_cpa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
